/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* hw/rtl/esc_pkg.sv */
package esc_pkg;

    localparam int N_CELLS = 64;

    localparam logic [2:0] CFG_TEMP    = 3'd0;
    localparam logic [2:0] CFG_PRES_LO = 3'd1;
    localparam logic [2:0] CFG_PRES_HI = 3'd2;
    localparam logic [2:0] CFG_PRES_P9 = 3'd3;
    localparam logic [2:0] CFG_HUM     = 3'd4;

    localparam logic signed [32:0] FINE_T_PRES_OFFSET = 33'sd128000;
    localparam logic [20:0]        PRES_RAW_BASE      = 21'd1048576;
    localparam logic signed [63:0] PRES_SCALE         = 64'sd3125;
    localparam logic signed [63:0] PRES_X_BIAS        = 64'sh0000_8000_0000_0000;
    localparam logic signed [31:0] FINE_T_HUM_OFFSET  = 32'sd76800;
    localparam logic signed [31:0] HUM_LIMIT          = 32'sd419430400;
    localparam logic signed [31:0] HUM_BIAS_A         = 32'sd2097152;
    localparam logic signed [31:0] HUM_ROUND_A        = 32'sd16384;
    localparam logic signed [31:0] HUM_BIAS_B         = 32'sd32768;
    localparam logic signed [31:0] HUM_ROUND_B        = 32'sd8192;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] pres_lo;
        logic [63:0] pres_hi;
        logic [15:0] p9;
        logic [63:0] hum;
    } t_coeffs;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [63:0] md;
        logic [15:0] tc;
        logic [16:0] hum;
    } t_div_pl;

    typedef struct packed {
        logic        valid;
        logic [63:0] rem;
        logic [63:0] num;
        t_div_pl     pl;
    } t_cell_bus;

endpackage

/* hw/rtl/esc_front.sv */
module esc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [19:0]         i_raw_temperature,
    input  logic [19:0]         i_raw_pressure,
    input  logic [15:0]         i_raw_humidity,
    input  esc_pkg::t_coeffs    i_coeffs,
    output esc_pkg::t_cell_bus  o_cell
);

    logic [15:0]        w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_h2;
    logic [7:0]         w_h1, w_h3;
    logic signed [11:0] w_h4, w_h5;
    logic signed [7:0]  w_h6;

    assign w_t1 = i_coeffs.temp[15:0];
    assign w_t2 = $signed(i_coeffs.temp[31:16]);
    assign w_t3 = $signed(i_coeffs.temp[47:32]);
    assign w_p1 = i_coeffs.pres_lo[15:0];
    assign w_p2 = $signed(i_coeffs.pres_lo[31:16]);
    assign w_p3 = $signed(i_coeffs.pres_lo[47:32]);
    assign w_p4 = $signed(i_coeffs.pres_lo[63:48]);
    assign w_p5 = $signed(i_coeffs.pres_hi[15:0]);
    assign w_p6 = $signed(i_coeffs.pres_hi[31:16]);
    assign w_h1 = i_coeffs.hum[7:0];
    assign w_h2 = $signed(i_coeffs.hum[23:8]);
    assign w_h3 = i_coeffs.hum[31:24];
    assign w_h4 = $signed(i_coeffs.hum[43:32]);
    assign w_h5 = $signed(i_coeffs.hum[55:44]);
    assign w_h6 = $signed(i_coeffs.hum[63:56]);

    logic [10:0] r_vld;

    // stage 1
    logic signed [17:0] n1_diff;
    logic signed [16:0] n1_d;
    logic signed [33:0] n1_ta_full, n1_dd_full;
    logic signed [31:0] r1_ta, r1_dd;
    logic [19:0]        r1_ap;
    logic [15:0]        r1_ah;
    // stage 2
    logic signed [31:0] n2_m, r2_a, r2_m;
    logic [19:0]        r2_ap;
    logic [15:0]        r2_ah;
    // stage 3
    logic signed [31:0] r3_fine;
    logic [19:0]        r3_ap;
    logic [15:0]        r3_ah;
    // stage 4
    logic signed [31:0] n4_t5, n4_tsh, n4_v;
    logic [15:0]        n4_tc;
    logic signed [32:0] n4_x;
    logic signed [65:0] n4_xx_full;
    logic signed [48:0] n4_xp5_full, n4_xp2_full;
    logic signed [63:0] r4_xx, r4_xp5, r4_xp2;
    logic signed [31:0] r4_h5v, r4_v6, r4_v3h;
    logic [15:0]        r4_tc;
    logic [19:0]        r4_ap;
    logic [15:0]        r4_ah;
    // stage 5
    logic signed [31:0] n5_upre;
    logic signed [63:0] r5_ya, r5_yb, r5_xxp3, r5_xp2;
    logic signed [31:0] r5_u, r5_wa, r5_wb;
    logic [15:0]        r5_tc;
    logic [19:0]        r5_ap;
    // stage 6
    logic signed [63:0] r6_y, r6_x2;
    logic signed [31:0] r6_hw, r6_u;
    logic [15:0]        r6_tc;
    logic [19:0]        r6_ap;
    // stage 7
    logic [20:0]        n7_pb;
    logic signed [63:0] r7_x3p, r7_num0;
    logic signed [31:0] r7_hwh, r7_u;
    logic [15:0]        r7_tc;
    // stage 8
    logic signed [63:0] r8_x3, r8_num;
    logic signed [31:0] r8_vu;
    logic [15:0]        r8_tc;
    // stage 9
    logic signed [31:0] n9_vs;
    logic [63:0]        r9_mn, r9_md;
    logic               r9_neg, r9_zero;
    logic signed [31:0] r9_sq, r9_vu;
    logic [15:0]        r9_tc;
    // stage 10
    logic [63:0]        r10_mn, r10_md;
    logic               r10_neg, r10_zero;
    logic signed [31:0] r10_t, r10_vu;
    logic [15:0]        r10_tc;
    // stage 11
    logic signed [31:0] n11_hs;
    logic [16:0]        n11_hum;
    logic [63:0]        r11_mn, r11_md;
    logic               r11_neg, r11_zero;
    logic [15:0]        r11_tc;
    logic [16:0]        r11_hum;

    always_comb begin
        n1_diff    = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, w_t1, 1'b0});
        n1_d       = $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, w_t1});
        n1_ta_full = n1_diff * w_t2;
        n1_dd_full = n1_d * n1_d;

        n2_m = (r1_dd >>> 12) * w_t3;

        n4_t5  = r3_fine + (r3_fine <<< 2) + 32'sd128;
        n4_tsh = n4_t5 >>> 8;
        if (n4_tsh < -32'sd32768) begin
            n4_tc = 16'h8000;
        end else if (n4_tsh > 32'sd32767) begin
            n4_tc = 16'h7fff;
        end else begin
            n4_tc = n4_tsh[15:0];
        end
        n4_x        = $signed({r3_fine[31], r3_fine}) - esc_pkg::FINE_T_PRES_OFFSET;
        n4_xx_full  = n4_x * n4_x;
        n4_xp5_full = n4_x * w_p5;
        n4_xp2_full = n4_x * w_p2;
        n4_v        = r3_fine - esc_pkg::FINE_T_HUM_OFFSET;

        n5_upre = $signed({2'b00, r4_ah, 14'b0}) - $signed({w_h4, 20'b0}) - r4_h5v
                  + esc_pkg::HUM_ROUND_A;

        n7_pb = esc_pkg::PRES_RAW_BASE - {1'b0, r6_ap};

        n9_vs = r8_vu >>> 15;

        n11_hs = r10_vu - (r10_t >>> 4);
        if (n11_hs < 32'sd0) begin
            n11_hum = 17'd0;
        end else if (n11_hs > esc_pkg::HUM_LIMIT) begin
            n11_hum = esc_pkg::HUM_LIMIT[28:12];
        end else begin
            n11_hum = n11_hs[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[9:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ta <= n1_ta_full[31:0];
            r1_dd <= n1_dd_full[31:0];
            r1_ap <= i_raw_pressure;
            r1_ah <= i_raw_humidity;

            r2_a  <= r1_ta >>> 11;
            r2_m  <= n2_m;
            r2_ap <= r1_ap;
            r2_ah <= r1_ah;

            r3_fine <= r2_a + (r2_m >>> 14);
            r3_ap   <= r2_ap;
            r3_ah   <= r2_ah;

            r4_xx  <= n4_xx_full[63:0];
            r4_xp5 <= {n4_xp5_full[46:0], 17'b0};
            r4_xp2 <= {{3{n4_xp2_full[48]}}, n4_xp2_full, 12'b0};
            r4_h5v <= n4_v * w_h5;
            r4_v6  <= n4_v * w_h6;
            r4_v3h <= n4_v * $signed({1'b0, w_h3});
            r4_tc  <= n4_tc;
            r4_ap  <= r3_ap;
            r4_ah  <= r3_ah;

            r5_ya   <= r4_xx * w_p6;
            r5_xxp3 <= r4_xx * w_p3;
            r5_yb   <= r4_xp5 + $signed({{13{w_p4[15]}}, w_p4, 35'b0});
            r5_xp2  <= r4_xp2;
            r5_u    <= n5_upre >>> 15;
            r5_wa   <= r4_v6 >>> 10;
            r5_wb   <= (r4_v3h >>> 11) + esc_pkg::HUM_BIAS_B;
            r5_tc   <= r4_tc;
            r5_ap   <= r4_ap;

            r6_y  <= r5_ya + r5_yb;
            r6_x2 <= (r5_xxp3 >>> 8) + r5_xp2;
            r6_hw <= r5_wa * r5_wb;
            r6_u  <= r5_u;
            r6_tc <= r5_tc;
            r6_ap <= r5_ap;

            r7_x3p  <= (r6_x2 + esc_pkg::PRES_X_BIAS) * $signed({48'b0, w_p1});
            r7_num0 <= $signed({12'b0, n7_pb, 31'b0}) - r6_y;
            r7_hwh  <= ((r6_hw >>> 10) + esc_pkg::HUM_BIAS_A) * w_h2;
            r7_u    <= r6_u;
            r7_tc   <= r6_tc;

            r8_x3  <= r7_x3p >>> 33;
            r8_num <= r7_num0 * esc_pkg::PRES_SCALE;
            r8_vu  <= r7_u * ((r7_hwh + esc_pkg::HUM_ROUND_B) >>> 14);
            r8_tc  <= r7_tc;

            r9_mn   <= r8_num[63] ? (64'd0 - r8_num) : r8_num;
            r9_md   <= r8_x3[63] ? (64'd0 - r8_x3) : r8_x3;
            r9_neg  <= r8_num[63] ^ r8_x3[63];
            r9_zero <= (r8_x3 == 64'sd0);
            r9_sq   <= n9_vs * n9_vs;
            r9_vu   <= r8_vu;
            r9_tc   <= r8_tc;

            r10_mn   <= r9_mn;
            r10_md   <= r9_md;
            r10_neg  <= r9_neg;
            r10_zero <= r9_zero;
            r10_t    <= (r9_sq >>> 7) * $signed({1'b0, w_h1});
            r10_vu   <= r9_vu;
            r10_tc   <= r9_tc;

            r11_mn   <= r10_mn;
            r11_md   <= r10_md;
            r11_neg  <= r10_neg;
            r11_zero <= r10_zero;
            r11_tc   <= r10_tc;
            r11_hum  <= n11_hum;
        end
    end

    always_comb begin
        o_cell.valid   = r_vld[10];
        o_cell.rem     = 64'd0;
        o_cell.num     = r11_mn;
        o_cell.pl.neg  = r11_neg;
        o_cell.pl.zero = r11_zero;
        o_cell.pl.md   = r11_md;
        o_cell.pl.tc   = r11_tc;
        o_cell.pl.hum  = r11_hum;
    end

endmodule

/* hw/rtl/esc_div_cell.sv */
module esc_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  esc_pkg::t_cell_bus  i_cell,
    output esc_pkg::t_cell_bus  o_cell
);

    logic [64:0]        w_sh, w_diff;
    logic               w_ge;
    esc_pkg::t_cell_bus n_cell, r_cell;

    // one restoring step: shift in the next numerator bit, trial subtract
    always_comb begin
        w_sh         = {i_cell.rem, i_cell.num[63]};
        w_diff       = w_sh - {1'b0, i_cell.pl.md};
        w_ge         = !w_diff[64];
        n_cell       = i_cell;
        n_cell.rem   = w_ge ? w_diff[63:0] : w_sh[63:0];
        n_cell.num   = {i_cell.num[62:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.rem <= n_cell.rem;
            r_cell.num <= n_cell.num;
            r_cell.pl  <= n_cell.pl;
        end
    end

    assign o_cell = r_cell;

endmodule

/* hw/rtl/esc_back.sv */
module esc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  esc_pkg::t_cell_bus  i_cell,
    input  esc_pkg::t_coeffs    i_coeffs,
    output logic                o_valid,
    output logic signed [15:0]  o_temperature_centi,
    output logic [31:0]         o_pressure_q8,
    output logic                o_pressure_valid,
    output logic [16:0]         o_humidity_q10
);

    logic signed [15:0] w_p7, w_p8, w_p9;

    assign w_p7 = $signed(i_coeffs.pres_hi[47:32]);
    assign w_p8 = $signed(i_coeffs.pres_hi[63:48]);
    assign w_p9 = $signed(i_coeffs.p9);

    logic [5:0] r_vld;

    logic signed [63:0] r1_p;
    logic signed [63:0] n2_ps;
    logic [63:0]        r2_ll;
    logic [31:0]        r2_lh;
    logic signed [63:0] r2_fm, r2_p;
    logic [63:0]        r3_pss;
    logic signed [63:0] r3_f, r3_p;
    logic signed [63:0] r4_em, r4_f, r4_p;
    logic signed [63:0] r5_sum;
    logic signed [63:0] n6_r;
    logic [31:0]        n6_pq;
    logic [4:0]         r_zero;
    logic [15:0]        r1_tc, r2_tc, r3_tc, r4_tc, r5_tc;
    logic [16:0]        r1_hum, r2_hum, r3_hum, r4_hum, r5_hum;
    logic [15:0]        r6_tc;
    logic [16:0]        r6_hum;
    logic [31:0]        r6_pq;
    logic               r6_pvalid;

    always_comb begin
        n2_ps = r1_p >>> 13;
        n6_r  = (r5_sum >>> 8) + $signed({{44{w_p7[15]}}, w_p7, 4'b0});
        if (r_zero[4] || n6_r < 64'sd0) begin
            n6_pq = 32'd0;
        end else if (n6_r[63:32] != 32'd0) begin
            n6_pq = 32'hffff_ffff;
        end else begin
            n6_pq = n6_r[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_cell.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p   <= i_cell.pl.neg ? $signed(64'd0 - i_cell.num) : $signed(i_cell.num);
            r_zero <= {r_zero[3:0], i_cell.pl.zero};
            r1_tc  <= i_cell.pl.tc;
            r1_hum <= i_cell.pl.hum;

            // square of the scaled quotient, low word only, in partial products
            r2_ll  <= {32'd0, n2_ps[31:0]} * {32'd0, n2_ps[31:0]};
            r2_lh  <= n2_ps[31:0] * n2_ps[63:32];
            r2_fm  <= r1_p * w_p8;
            r2_p   <= r1_p;
            r2_tc  <= r1_tc;
            r2_hum <= r1_hum;

            r3_pss <= r2_ll + {r2_lh[30:0], 1'b0, 32'b0};
            r3_f   <= r2_fm >>> 19;
            r3_p   <= r2_p;
            r3_tc  <= r2_tc;
            r3_hum <= r2_hum;

            r4_em  <= $signed(r3_pss) * w_p9;
            r4_f   <= r3_f;
            r4_p   <= r3_p;
            r4_tc  <= r3_tc;
            r4_hum <= r3_hum;

            r5_sum <= r4_p + (r4_em >>> 25) + r4_f;
            r5_tc  <= r4_tc;
            r5_hum <= r4_hum;

            r6_pq     <= n6_pq;
            r6_pvalid <= !r_zero[4];
            r6_tc     <= r5_tc;
            r6_hum    <= r5_hum;
        end
    end

    assign o_valid             = r_vld[5];
    assign o_temperature_centi = $signed(r6_tc);
    assign o_pressure_q8       = r6_pq;
    assign o_pressure_valid    = r6_pvalid;
    assign o_humidity_q10      = r6_hum;

endmodule

/* hw/rtl/env_sensor_compensation.sv */
// Integer compensation of one raw temperature / pressure / humidity sample per transaction.
// Takes one sample per clock while not stalled and returns results in order through 11 front
// stages (fine temperature, temperature, humidity, pressure numerator and divisor), a row
// of 64 divider cells that resolve one quotient bit each, and 6 back stages for the
// pressure correction and output register. The whole pipeline holds while a result is stalled
// at the output, and input is stalled only then. The user must write calibration words through
// the configuration port only while no sample is in flight; the block does not enforce this.
`include "assert_macros.svh"

module env_sensor_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    input  logic [15:0]        i_raw_humidity,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_temperature_centi,
    output logic [31:0]        o_pressure_q8,
    output logic               o_pressure_valid,
    output logic [16:0]        o_humidity_q10,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    logic [47:0]      r_temp_coeffs;
    logic [63:0]      r_pres_coeffs_low;
    logic [63:0]      r_pres_coeffs_high;
    logic [15:0]      r_pres_coeff_nine;
    logic [63:0]      r_hum_coeffs;
    esc_pkg::t_coeffs w_coeffs;
    logic             w_en;
    logic             w_p9_write;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs      <= '0;
            r_pres_coeffs_low  <= '0;
            r_pres_coeffs_high <= '0;
            r_pres_coeff_nine  <= '0;
            r_hum_coeffs       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                esc_pkg::CFG_TEMP:    r_temp_coeffs      <= i_cfg_data[47:0];
                esc_pkg::CFG_PRES_LO: r_pres_coeffs_low  <= i_cfg_data;
                esc_pkg::CFG_PRES_HI: r_pres_coeffs_high <= i_cfg_data;
                esc_pkg::CFG_PRES_P9: r_pres_coeff_nine  <= i_cfg_data[15:0];
                esc_pkg::CFG_HUM:     r_hum_coeffs       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_coeffs.temp    = r_temp_coeffs;
        w_coeffs.pres_lo = r_pres_coeffs_low;
        w_coeffs.pres_hi = r_pres_coeffs_high;
        w_coeffs.p9      = r_pres_coeff_nine;
        w_coeffs.hum     = r_hum_coeffs;
    end

    // pipeline advances unless a finished result is held at the output
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    esc_pkg::t_cell_bus w_row [0:esc_pkg::N_CELLS];

    esc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_valid           (i_in_valid),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_humidity    (i_raw_humidity),
        .i_coeffs          (w_coeffs),
        .o_cell            (w_row[0])
    );

    for (genvar g = 0; g < esc_pkg::N_CELLS; g++) begin : g_cell
        esc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_row[g]),
            .o_cell  (w_row[g+1])
        );
    end

    esc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (w_en),
        .i_cell              (w_row[esc_pkg::N_CELLS]),
        .i_coeffs            (w_coeffs),
        .o_valid             (o_out_valid),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_q8       (o_pressure_q8),
        .o_pressure_valid    (o_pressure_valid),
        .o_humidity_q10      (o_humidity_q10)
    );

    assign w_p9_write = i_cfg_valid && o_cfg_ready && i_cfg_index == esc_pkg::CFG_PRES_P9;

    `ASSERT_IMPLIES(a_pres_zero, i_clk, i_rst_n, o_out_valid && !o_pressure_valid, o_pressure_q8 == '0)
    `ASSERT_IMPLIES(a_hum_range, i_clk, i_rst_n, o_out_valid, o_humidity_q10 <= 17'd102400)
    `ASSERT_NEXT(a_cfg_p9, i_clk, i_rst_n, w_p9_write, r_pres_coeff_nine == $past(i_cfg_data[15:0]))

endmodule
